FILE: rtl/btpl_pkg.sv
`default_nettype none
// ============================================================================
// btpl_pkg: shared types and constants for the binary trie prefix lookup
// Node layout, store size and sequencer states used by the lookup core.
// ============================================================================

package btpl_pkg;

    // Size of the node store and the widths that follow from it.
    localparam int NODES  = 65536;
    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int HOP_W  = 8;
    localparam int NODE_W = 1 + HOP_W + 2 * IDX_W;

    // Deepest level of the trie, one level per address bit.
    localparam logic [LEN_W-1:0] MAX_DEPTH = 6'd32;

    // Operation codes carried by the op field.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_e;

    // One trie node: next hop marker, next hop, and the two child links.
    // A child link of zero means no child, since the root is never a child.
    typedef struct packed {
        logic             has_hop;
        logic [HOP_W-1:0] hop;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    // Sequencer states of the walk.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/btpl_ram.sv
`default_nettype none
// ============================================================================
// btpl_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================

module btpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/binary_trie_prefix_lookup_core.sv
`default_nettype none
// ============================================================================
// binary_trie_prefix_lookup_core: IPv4 longest-prefix-match engine
// Binary trie with one address bit per level, walked by a small sequencer.
// ============================================================================
//
// Usage:
// - Input channel (in_valid / in_stall) carries one beat per operation:
//   op = insert a route (addr, prefix_len, hop_in) or look up addr.
// - Output channel (out_valid / out_stall) returns exactly one beat per
//   input beat: found and hop_out for lookups, full_error for inserts.
// - One operation is worked on at a time; in_stall is high from the accept
//   until the result is loaded into the output register. A lookup walk
//   visits one trie level per cycle through the node store's registered
//   read port and ends at depth 32 or at a missing child; the result is
//   then loaded, and the next beat can be accepted once it is.
//   An insert steps through each existing level; each new node takes a
//   parent link write, then a child clearing write on the single write
//   port; then the target node is marked if unmarked and the result loaded.
// - The root node lives in flip-flops, so reset empties the trie at once
//   and no clearing pass is needed; the node count resets to one.
// - A finished result waits in the output register while out_stall is
//   high; the next beat can already be accepted, and its walk holds in the
//   done state until the output register is free.
//
module binary_trie_prefix_lookup_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         op,
    input  wire logic [btpl_pkg::ADDR_W-1:0]  addr,
    input  wire logic [btpl_pkg::LEN_W-1:0]   prefix_len,
    input  wire logic [btpl_pkg::HOP_W-1:0]   hop_in,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic      [btpl_pkg::HOP_W-1:0]   hop_out,
    output logic                              full_error
);

    import btpl_pkg::*;

    // Sequencer and walk registers.
    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [HOP_W-1:0]  hop_in_reg, hop_in_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]  depth_reg, depth_next;
    logic              fresh_reg, fresh_next;
    logic              hit_reg, hit_next;
    logic [HOP_W-1:0]  hop_acc_reg, hop_acc_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    node_t             root_reg, root_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [HOP_W-1:0]  hop_out_reg, hop_out_next;
    logic              full_error_reg, full_error_next;

    // Node store ports.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    node_t             ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [NODE_W-1:0] ram_rdata;

    // Walk datapath.
    node_t             node_cur;
    node_t             node_upd;
    logic              node_wr;
    logic              addr_bit;
    logic [4:0]        bit_sel;
    logic [IDX_W-1:0]  link;
    logic              out_free;
    logic              in_fire;

    btpl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake terms.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Current node: root flops, a just-allocated empty node, or read data.
    always_comb
    begin
        if (cur_reg == '0)
        begin
            node_cur = root_reg;
        end
        else if (fresh_reg)
        begin
            node_cur = '0;
        end
        else
        begin
            node_cur = node_t'(ram_rdata);
        end
    end

    // Address bit for the current depth, most significant bit first.
    assign bit_sel  = ~depth_reg[4:0];
    assign addr_bit = addr_reg[bit_sel];
    assign link     = addr_bit ? node_cur.right : node_cur.left;

    // State register and walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= CNT_W'(1);
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        hop_in_reg     <= hop_in_next;
        cur_reg        <= cur_next;
        depth_reg      <= depth_next;
        fresh_reg      <= fresh_next;
        hit_reg        <= hit_next;
        hop_acc_reg    <= hop_acc_next;
        err_reg        <= err_next;
        found_reg      <= found_next;
        hop_out_reg    <= hop_out_next;
        full_error_reg <= full_error_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        hop_in_next     = hop_in_reg;
        cur_next        = cur_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        hit_next        = hit_reg;
        hop_acc_next    = hop_acc_reg;
        err_next        = err_reg;
        used_next       = used_reg;
        root_next       = root_reg;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        hop_out_next    = hop_out_reg;
        full_error_next = full_error_reg;
        ram_re          = 1'b0;
        ram_raddr       = link;
        node_wr         = 1'b0;
        node_upd        = node_cur;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = node_upd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next      = op;
                    addr_next    = addr;
                    len_next     = (prefix_len > MAX_DEPTH) ? MAX_DEPTH : prefix_len;
                    hop_in_next  = hop_in;
                    cur_next     = '0;
                    depth_next   = '0;
                    fresh_next   = 1'b0;
                    hit_next     = 1'b0;
                    hop_acc_next = '0;
                    err_next     = 1'b0;
                    // A zero-length insert changes nothing.
                    if (op == OP_INSERT && prefix_len == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    // Remember the deepest marked node seen so far.
                    if (node_cur.has_hop)
                    begin
                        hit_next     = 1'b1;
                        hop_acc_next = node_cur.hop;
                    end
                    if (depth_reg == MAX_DEPTH || link == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        cur_next   = link;
                        depth_next = depth_reg + LEN_W'(1);
                        fresh_next = 1'b0;
                    end
                end
                else if (depth_reg == len_reg)
                begin
                    // Target node of an insert: the first insert wins.
                    if (!node_cur.has_hop)
                    begin
                        node_wr          = 1'b1;
                        node_upd.has_hop = 1'b1;
                        node_upd.hop     = hop_in_reg;
                    end
                    state_next = ST_DONE;
                end
                else if (link == '0)
                begin
                    if (used_reg >= CNT_W'(NODES))
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Link the parent to the next free node.
                        node_wr = 1'b1;
                        if (addr_bit)
                        begin
                            node_upd.right = used_reg[IDX_W-1:0];
                        end
                        else
                        begin
                            node_upd.left = used_reg[IDX_W-1:0];
                        end
                        cur_next   = used_reg[IDX_W-1:0];
                        used_next  = used_reg + CNT_W'(1);
                        state_next = ST_ALLOC;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    cur_next   = link;
                    depth_next = depth_reg + LEN_W'(1);
                    fresh_next = 1'b0;
                end
            end

            ST_ALLOC:
            begin
                // Clear the new node; it is known empty for the next level.
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = '0;
                fresh_next = 1'b1;
                depth_next = depth_reg + LEN_W'(1);
                state_next = ST_WALK;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = (op_reg == OP_LOOKUP) && hit_reg;
                    hop_out_next    = ((op_reg == OP_LOOKUP) && hit_reg) ? hop_acc_reg : '0;
                    full_error_next = (op_reg == OP_INSERT) && err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Node updates go to the root flops or to the node store.
        if (node_wr)
        begin
            if (cur_reg == '0)
            begin
                root_next = node_upd;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = node_upd;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign hop_out    = hop_out_reg;
    assign full_error = full_error_reg;

    // The node count never passes the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NODES))
        else $error("node count exceeds store size");

    // Nodes are allocated at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (used_reg == $past(used_reg) || used_reg == $past(used_reg) + CNT_W'(1)))
        else $error("node count jumped");

    // The root lives in flops and is never written to the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("store write to the root entry");

    // A result beat never flags both a match and a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && full_error))
        else $error("lookup and insert flags both set");

    // An accepted beat starts a walk or finishes a zero-length insert.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_WALK || state_reg == ST_DONE))
        else $error("accepted beat did not start work");

endmodule

`default_nettype wire
